// ----- design/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants of the lookahead point search block: item
// structs, command codes, register addresses and fixed field widths.
// ----------------------------------------------------------------------------
package lps_pkg;

  // fixed field widths
  localparam int COORD_BITS = 24;
  localparam int SLOT_W     = 8;
  localparam int TIDX_W     = 8;
  localparam int LA_W       = 24;
  localparam int CNT_REG_W  = 9;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // derived arithmetic widths
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int DSQ_W  = SQ_W + 1;
  localparam int LIM_W  = 2 * LA_W;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register byte addresses
  localparam logic [APB_AW-1:0] ADDR_LOOKAHEAD = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_COUNT     = 3'd4;

  // default store depth
  localparam int MAX_POINTS_DEF = 256;

  typedef struct packed {
    logic                          cmd;
    logic [SLOT_W-1:0]             point_slot;
    logic signed [COORD_BITS-1:0]  coord_x;
    logic signed [COORD_BITS-1:0]  coord_y;
  } in_item_t;

  typedef struct packed {
    logic [TIDX_W-1:0]             target_index;
    logic signed [COORD_BITS-1:0]  target_x;
    logic signed [COORD_BITS-1:0]  target_y;
    logic                          in_range;
  } out_item_t;

  // control that travels with a point through the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } scan_ctl_t;

endpackage

// ----- design/lps_cell.sv -----
// ----------------------------------------------------------------------------
// lps_cell
// One storage cell of the point ring: holds one path point, written by its
// own slot on a load and taking its neighbor's point on each scan step.
// ----------------------------------------------------------------------------
module lps_cell (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic signed [lps_pkg::COORD_BITS-1:0] wr_x,
  input  logic signed [lps_pkg::COORD_BITS-1:0] wr_y,
  input  logic                                  shift_en,
  input  logic signed [lps_pkg::COORD_BITS-1:0] nb_x,
  input  logic signed [lps_pkg::COORD_BITS-1:0] nb_y,
  output logic signed [lps_pkg::COORD_BITS-1:0] pt_x,
  output logic signed [lps_pkg::COORD_BITS-1:0] pt_y
);

  logic signed [lps_pkg::COORD_BITS-1:0] x_r;
  logic signed [lps_pkg::COORD_BITS-1:0] y_r;

  // load by slot, otherwise rotate along the ring
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (shift_en) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

  assign pt_x = x_r;
  assign pt_y = y_r;

endmodule

// ----- design/lps_dist.sv -----
// ----------------------------------------------------------------------------
// lps_dist
// Three-stage squared distance unit: absolute differences, squares, sum.
// Carries the point, its index and scan control alongside.
// ----------------------------------------------------------------------------
module lps_dist #(
  parameter int IDX_W = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lps_pkg::scan_ctl_t                    ctl_in,
  input  logic [IDX_W-1:0]                      idx_in,
  input  logic signed [lps_pkg::COORD_BITS-1:0] pt_x_in,
  input  logic signed [lps_pkg::COORD_BITS-1:0] pt_y_in,
  input  logic signed [lps_pkg::COORD_BITS-1:0] rob_x,
  input  logic signed [lps_pkg::COORD_BITS-1:0] rob_y,
  output lps_pkg::scan_ctl_t                    ctl_out,
  output logic [IDX_W-1:0]                      idx_out,
  output logic signed [lps_pkg::COORD_BITS-1:0] pt_x_out,
  output logic signed [lps_pkg::COORD_BITS-1:0] pt_y_out,
  output logic [lps_pkg::DSQ_W-1:0]             dsq_out
);

  localparam int C  = lps_pkg::COORD_BITS;
  localparam int DW = lps_pkg::DIFF_W;
  localparam int SW = lps_pkg::SQ_W;

  lps_pkg::scan_ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic [IDX_W-1:0]   idx1_r, idx2_r, idx3_r;
  logic signed [C-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [DW-1:0]      dx_nxt, dy_nxt, dx_r, dy_r;
  logic [DW-1:0]      sdx, sdy;
  logic [SW-1:0]      sqx_r, sqy_r;
  logic [lps_pkg::DSQ_W-1:0] dsq_r;

  // signed differences in one extra bit, then magnitude
  always_comb begin
    sdx    = {pt_x_in[C-1], pt_x_in} - {rob_x[C-1], rob_x};
    sdy    = {pt_y_in[C-1], pt_y_in} - {rob_y[C-1], rob_y};
    dx_nxt = sdx[DW-1] ? (~sdx + DW'(1)) : sdx;
    dy_nxt = sdy[DW-1] ? (~sdy + DW'(1)) : sdy;
  end

  // scan control pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      ctl3_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      ctl3_r <= ctl2_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    idx1_r <= idx_in;
    x1_r   <= pt_x_in;
    y1_r   <= pt_y_in;

    sqx_r  <= SW'(dx_r) * SW'(dx_r);
    sqy_r  <= SW'(dy_r) * SW'(dy_r);
    idx2_r <= idx1_r;
    x2_r   <= x1_r;
    y2_r   <= y1_r;

    dsq_r  <= {1'b0, sqx_r} + {1'b0, sqy_r};
    idx3_r <= idx2_r;
    x3_r   <= x2_r;
    y3_r   <= y2_r;
  end

  assign ctl_out  = ctl3_r;
  assign idx_out  = idx3_r;
  assign pt_x_out = x3_r;
  assign pt_y_out = y3_r;
  assign dsq_out  = dsq_r;

endmodule

// ----- design/lps_pick.sv -----
// ----------------------------------------------------------------------------
// lps_pick
// Tracks the last in-range point, the nearest point and the point after the
// nearest one over a scan, and registers the chosen target at its end.
// ----------------------------------------------------------------------------
module lps_pick #(
  parameter int IDX_W = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  lps_pkg::scan_ctl_t                    ctl,
  input  logic [IDX_W-1:0]                      idx,
  input  logic signed [lps_pkg::COORD_BITS-1:0] pt_x,
  input  logic signed [lps_pkg::COORD_BITS-1:0] pt_y,
  input  logic [lps_pkg::DSQ_W-1:0]             dsq,
  input  logic [lps_pkg::LIM_W-1:0]             limit,
  output logic                                  res_valid,
  output logic [IDX_W-1:0]                      res_idx,
  output logic signed [lps_pkg::COORD_BITS-1:0] res_x,
  output logic signed [lps_pkg::COORD_BITS-1:0] res_y,
  output logic                                  res_in_range
);

  localparam int C  = lps_pkg::COORD_BITS;
  localparam int DW = lps_pkg::DSQ_W;
  localparam int LW = lps_pkg::LIM_W;
  localparam int CW = (DW > LW) ? DW : LW;

  logic                found_r, found_nxt;
  logic                want_r, want_nxt;
  logic                have_r, have_nxt;
  logic [DW-1:0]       best_r, best_nxt;
  logic [IDX_W-1:0]    pick_i_r, pick_i_nxt, near_i_r, near_i_nxt, next_i_r, next_i_nxt;
  logic signed [C-1:0] pick_x_r, pick_x_nxt, pick_y_r, pick_y_nxt;
  logic signed [C-1:0] near_x_r, near_x_nxt, near_y_r, near_y_nxt;
  logic signed [C-1:0] next_x_r, next_x_nxt, next_y_r, next_y_nxt;
  logic                lt_lim, lt_best;
  logic                res_valid_r, res_in_range_r;
  logic [IDX_W-1:0]    res_idx_r;
  logic signed [C-1:0] res_x_r, res_y_r;

  // running candidates
  always_comb begin
    found_nxt  = found_r;
    want_nxt   = want_r;
    have_nxt   = have_r;
    best_nxt   = best_r;
    pick_i_nxt = pick_i_r;
    pick_x_nxt = pick_x_r;
    pick_y_nxt = pick_y_r;
    near_i_nxt = near_i_r;
    near_x_nxt = near_x_r;
    near_y_nxt = near_y_r;
    next_i_nxt = next_i_r;
    next_x_nxt = next_x_r;
    next_y_nxt = next_y_r;
    lt_lim     = CW'(dsq) < CW'(limit);
    lt_best    = dsq < best_r;
    if (ctl.valid) begin
      if (idx == '0) begin
        // first point opens the scan
        found_nxt  = lt_lim;
        want_nxt   = 1'b1;
        have_nxt   = 1'b0;
        best_nxt   = dsq;
        near_i_nxt = idx;
        near_x_nxt = pt_x;
        near_y_nxt = pt_y;
        if (lt_lim) begin
          pick_i_nxt = idx;
          pick_x_nxt = pt_x;
          pick_y_nxt = pt_y;
        end
      end else begin
        // point right after the current nearest
        if (want_r) begin
          next_i_nxt = idx;
          next_x_nxt = pt_x;
          next_y_nxt = pt_y;
          have_nxt   = 1'b1;
          want_nxt   = 1'b0;
        end
        if (lt_lim) begin
          found_nxt  = 1'b1;
          pick_i_nxt = idx;
          pick_x_nxt = pt_x;
          pick_y_nxt = pt_y;
        end
        if (lt_best) begin
          best_nxt   = dsq;
          near_i_nxt = idx;
          near_x_nxt = pt_x;
          near_y_nxt = pt_y;
          want_nxt   = 1'b1;
          have_nxt   = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      want_r  <= 1'b0;
      have_r  <= 1'b0;
    end else begin
      found_r <= found_nxt;
      want_r  <= want_nxt;
      have_r  <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r   <= best_nxt;
    pick_i_r <= pick_i_nxt;
    pick_x_r <= pick_x_nxt;
    pick_y_r <= pick_y_nxt;
    near_i_r <= near_i_nxt;
    near_x_r <= near_x_nxt;
    near_y_r <= near_y_nxt;
    next_i_r <= next_i_nxt;
    next_x_r <= next_x_nxt;
    next_y_r <= next_y_nxt;
  end

  // result at end of scan: in-range pick, else point after nearest, else nearest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.last) begin
      res_in_range_r <= found_nxt;
      priority if (found_nxt) begin
        res_idx_r <= pick_i_nxt;
        res_x_r   <= pick_x_nxt;
        res_y_r   <= pick_y_nxt;
      end else if (have_nxt) begin
        res_idx_r <= next_i_nxt;
        res_x_r   <= next_x_nxt;
        res_y_r   <= next_y_nxt;
      end else begin
        res_idx_r <= near_i_nxt;
        res_x_r   <= near_x_nxt;
        res_y_r   <= near_y_nxt;
      end
    end
  end

  assign res_valid    = res_valid_r;
  assign res_idx      = res_idx_r;
  assign res_x        = res_x_r;
  assign res_y        = res_y_r;
  assign res_in_range = res_in_range_r;

endmodule

// ----- design/lookahead_point_search.sv -----
// ----------------------------------------------------------------------------
// lookahead_point_search
// Pure-pursuit lookahead point picker over a ring of path point cells.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. A load
//   item (cmd = load) writes its point into the cell of point_slot in that
//   edge and leaves busy low, so loads run one per cycle outside a query and
//   give no result. A query item raises busy; the point ring then rotates one
//   cell per cycle, feeding one point a cycle into the three-stage squared
//   distance unit, and a full turn leaves every point back in its own cell.
//   The result is shown on out_item with out_valid high for one cycle once
//   the last point has left the distance unit; busy drops at the edge that
//   ends that cycle. The scan length is set by the ring depth, not by
//   point_count. The receiver cannot stall: each result is taken in its
//   strobe cycle. Registers sit on the APB port (lookahead_distance at 0x0,
//   point_count at 0x4); the user must write them only while busy is low,
//   which the block does not enforce. Reset sets the lookahead to zero and
//   the point count to one; the point cells hold no reset value.
// ----------------------------------------------------------------------------
module lookahead_point_search #(
  parameter int MAX_POINTS = lps_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item channel
  input  logic                        start,
  output logic                        busy,
  input  lps_pkg::in_item_t           in_item,
  // result channel
  output logic                        out_valid,
  output lps_pkg::out_item_t          out_item,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::APB_AW-1:0]  paddr,
  input  logic [lps_pkg::APB_DW-1:0]  pwdata,
  output logic [lps_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int C     = lps_pkg::COORD_BITS;
  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int EW    = (CNT_W > lps_pkg::CNT_REG_W) ? CNT_W : lps_pkg::CNT_REG_W;
  localparam int SW    = (IDX_W > lps_pkg::SLOT_W) ? IDX_W : lps_pkg::SLOT_W;
  localparam int PW    = (IDX_W > lps_pkg::TIDX_W) ? IDX_W : lps_pkg::TIDX_W;

  logic [lps_pkg::LA_W-1:0]      la_r;
  logic [lps_pkg::CNT_REG_W-1:0] count_r;
  logic [lps_pkg::LIM_W-1:0]     limit_r;
  logic [CNT_W-1:0]              count_eff;
  logic [EW-1:0]                 count_ext;
  logic                          cfg_wr;
  logic                          take, do_load, do_query;
  logic                          busy_r, scan_r;
  logic [IDX_W-1:0]              cnt_r;
  logic signed [C-1:0]           rob_x_r, rob_y_r;
  logic [SW-1:0]                 slot_ext;
  logic signed [C-1:0]           cell_x [MAX_POINTS];
  logic signed [C-1:0]           cell_y [MAX_POINTS];
  lps_pkg::scan_ctl_t            feed_ctl, dist_ctl;
  logic [IDX_W-1:0]              dist_idx;
  logic signed [C-1:0]           dist_x, dist_y;
  logic [lps_pkg::DSQ_W-1:0]     dist_dsq;
  logic                          res_valid, res_in_range;
  logic [IDX_W-1:0]              res_idx;
  logic signed [C-1:0]           res_x, res_y;
  logic [PW-1:0]                 res_idx_ext;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r    <= '0;
      count_r <= lps_pkg::CNT_REG_W'(1);
    end else if (cfg_wr) begin
      if (paddr == lps_pkg::ADDR_LOOKAHEAD) begin
        la_r <= pwdata[lps_pkg::LA_W-1:0];
      end
      if (paddr == lps_pkg::ADDR_COUNT) begin
        count_r <= pwdata[lps_pkg::CNT_REG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lps_pkg::ADDR_LOOKAHEAD) begin
      prdata = lps_pkg::APB_DW'(la_r);
    end else if (paddr == lps_pkg::ADDR_COUNT) begin
      prdata = lps_pkg::APB_DW'(count_r);
    end
  end

  // squared lookahead radius
  always_ff @(posedge clk) begin
    limit_r <= lps_pkg::LIM_W'(la_r) * lps_pkg::LIM_W'(la_r);
  end

  // points in use, clamped to one..MAX_POINTS
  always_comb begin
    count_ext = EW'(count_r);
    if (count_r == '0) begin
      count_eff = CNT_W'(1);
    end else if (count_ext > EW'(MAX_POINTS)) begin
      count_eff = CNT_W'(MAX_POINTS);
    end else begin
      count_eff = CNT_W'(count_ext);
    end
  end

  // item acceptance
  assign take     = start && !busy_r;
  assign do_load  = take && (in_item.cmd == lps_pkg::CMD_LOAD);
  assign do_query = take && (in_item.cmd == lps_pkg::CMD_QUERY);
  assign slot_ext = SW'(in_item.point_slot);

  // scan sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      scan_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (do_query) begin
        busy_r <= 1'b1;
        scan_r <= 1'b1;
        cnt_r  <= '0;
      end else begin
        if (res_valid) begin
          busy_r <= 1'b0;
        end
        if (scan_r) begin
          cnt_r <= cnt_r + IDX_W'(1);
          if (cnt_r == IDX_W'(MAX_POINTS - 1)) begin
            scan_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_query) begin
      rob_x_r <= in_item.coord_x;
      rob_y_r <= in_item.coord_y;
    end
  end

  // point ring: cell k takes cell k+1, so cell zero holds point cnt_r
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    lps_cell u_cell (
      .clk      (clk),
      .wr_en    (do_load && (slot_ext == SW'(k))),
      .wr_x     (in_item.coord_x),
      .wr_y     (in_item.coord_y),
      .shift_en (scan_r),
      .nb_x     (cell_x[(k + 1) % MAX_POINTS]),
      .nb_y     (cell_y[(k + 1) % MAX_POINTS]),
      .pt_x     (cell_x[k]),
      .pt_y     (cell_y[k])
    );
  end

  // feed the head cell into the distance unit
  always_comb begin
    feed_ctl.valid = scan_r && (CNT_W'(cnt_r) < count_eff);
    feed_ctl.last  = scan_r && (cnt_r == IDX_W'(MAX_POINTS - 1));
  end

  lps_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (feed_ctl),
    .idx_in   (cnt_r),
    .pt_x_in  (cell_x[0]),
    .pt_y_in  (cell_y[0]),
    .rob_x    (rob_x_r),
    .rob_y    (rob_y_r),
    .ctl_out  (dist_ctl),
    .idx_out  (dist_idx),
    .pt_x_out (dist_x),
    .pt_y_out (dist_y),
    .dsq_out  (dist_dsq)
  );

  lps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (dist_ctl),
    .idx          (dist_idx),
    .pt_x         (dist_x),
    .pt_y         (dist_y),
    .dsq          (dist_dsq),
    .limit        (limit_r),
    .res_valid    (res_valid),
    .res_idx      (res_idx),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_in_range (res_in_range)
  );

  // result channel
  assign res_idx_ext           = PW'(res_idx);
  assign busy                  = busy_r;
  assign out_valid             = res_valid;
  assign out_item.target_index = res_idx_ext[lps_pkg::TIDX_W-1:0];
  assign out_item.target_x     = res_x;
  assign out_item.target_y     = res_y;
  assign out_item.in_range     = res_in_range;

  // checks
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy_r)
    else $error("result strobe outside a query");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    do_query |=> (scan_r && busy_r && (cnt_r == '0)))
    else $error("query did not start a scan");

  a_scan_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r |-> busy_r)
    else $error("ring rotating while idle");

  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && (paddr == lps_pkg::ADDR_COUNT))
      |=> (count_r == $past(pwdata[lps_pkg::CNT_REG_W-1:0])))
    else $error("point count write lost");

endmodule

// ----- bench/lookahead_target_checker.sv -----
// ----------------------------------------------------------------------------
// lookahead_target_checker
// Watches the item, result and register channels of the lookahead point
// search block. It keeps its own copy of the path point store and of the two
// registers, works out the expected target for every accepted query, and
// compares each strobed result with the oldest expected target. The failure
// count and the number of targets still awaited go to the testbench top.
// ----------------------------------------------------------------------------
module lookahead_target_checker #(
  parameter int MAX_POINTS = lps_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  lps_pkg::in_item_t           in_item,
  input  logic                        out_valid,
  input  lps_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps_pkg::APB_AW-1:0]  paddr,
  input  logic [lps_pkg::APB_DW-1:0]  pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending_results
);
  import lps_pkg::*;

  // shadow path store and registers
  logic signed [COORD_BITS-1:0] path_x [MAX_POINTS];
  logic signed [COORD_BITS-1:0] path_y [MAX_POINTS];
  logic [LA_W-1:0]              radius_q;
  logic [CNT_REG_W-1:0]         count_q;

  out_item_t expected_targets[$];
  int        failures = 0;

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  // squared distance from a stored point to the robot, exact in 64 bits
  function automatic longint dist_sq(input int idx,
                                     input logic signed [COORD_BITS-1:0] rx,
                                     input logic signed [COORD_BITS-1:0] ry);
    longint dx;
    longint dy;
    dx = longint'(path_x[idx]) - longint'(rx);
    dy = longint'(path_y[idx]) - longint'(ry);
    return dx * dx + dy * dy;
  endfunction

  // lookahead target for a robot position
  function automatic out_item_t predict_target(input logic signed [COORD_BITS-1:0] rx,
                                               input logic signed [COORD_BITS-1:0] ry);
    longint    limit;
    longint    best;
    longint    pt_dsq;
    int        scan_len;
    int        pick;
    int        nearest;
    bit        found;
    out_item_t res;
    scan_len = int'(count_q);
    if (scan_len == 0) scan_len = 1;
    if (scan_len > MAX_POINTS) scan_len = MAX_POINTS;
    limit   = longint'(radius_q) * longint'(radius_q);
    found   = 1'b0;
    pick    = 0;
    nearest = 0;
    best    = dist_sq(0, rx, ry);
    for (int i = 0; i < scan_len; i++) begin
      pt_dsq = dist_sq(i, rx, ry);
      // highest index strictly inside the radius wins
      if (pt_dsq < limit) begin
        pick  = i;
        found = 1'b1;
      end
      // nearest point, first one on ties
      if (pt_dsq < best) begin
        best    = pt_dsq;
        nearest = i;
      end
    end
    // fallback: point after the nearest, or the nearest when it is the last
    if (!found) pick = (nearest + 1 < scan_len) ? nearest + 1 : nearest;
    res.target_index = pick[TIDX_W-1:0];
    res.target_x     = path_x[pick];
    res.target_y     = path_y[pick];
    res.in_range     = found;
    return res;
  endfunction

  // snoop, predict and compare
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      radius_q = '0;
      count_q  = CNT_REG_W'(1);
      expected_targets.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_LOOKAHEAD: radius_q = pwdata[LA_W-1:0];
          ADDR_COUNT:     count_q  = pwdata[CNT_REG_W-1:0];
          default: ;
        endcase
      end
      // accepted item
      if (start && !busy) begin
        if (in_item.cmd == CMD_LOAD) begin
          path_x[in_item.point_slot] = in_item.coord_x;
          path_y[in_item.point_slot] = in_item.coord_y;
        end else begin
          want = predict_target(in_item.coord_x, in_item.coord_y);
          expected_targets = {expected_targets, want};
        end
      end
      // strobed result
      if (out_valid) begin
        if (expected_targets.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: index %0d x %0d y %0d in_range %0b",
                     out_item.target_index, out_item.target_x, out_item.target_y,
                     out_item.in_range);
        end else begin
          want = expected_targets.pop_front();
          if (out_item.target_index !== want.target_index ||
              out_item.target_x !== want.target_x ||
              out_item.target_y !== want.target_y ||
              out_item.in_range !== want.in_range) begin
            failures++;
            if (failures <= 10)
              $display({"target mismatch: exp index %0d x %0d y %0d in_range %0b, ",
                        "got index %0d x %0d y %0d in_range %0b"},
                       want.target_index, want.target_x, want.target_y, want.in_range,
                       out_item.target_index, out_item.target_x, out_item.target_y,
                       out_item.in_range);
          end
        end
      end
    end
    fail_count      <= failures;
    pending_results <= expected_targets.size();
  end

endmodule

// ----- bench/tb_lookahead_point_search.sv -----
// ----------------------------------------------------------------------------
// tb_lookahead_point_search
// Drives load and query items and register writes into the lookahead point
// search block with random gaps, first a directed set of extremes, ties and
// boundary distances, then random phases over several radius and point
// count settings. A checker module beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_lookahead_point_search;
  import lps_pkg::*;

  localparam int     MAX_POINTS      = MAX_POINTS_DEF;
  localparam int     NUM_PHASES      = 8;
  localparam int     ITEMS_PER_PHASE = 230;
  localparam longint CYCLE_LIMIT     = 4000000;
  localparam longint COORD_MIN       = -(longint'(1) << (COORD_BITS - 1));
  localparam longint COORD_MAX       = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam logic [LA_W-1:0] RADIUS_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_item_t            in_item;
  logic                out_valid;
  out_item_t           out_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  int                  fail_count;
  int                  pending_results;

  // stimulus bookkeeping
  bit                  written [MAX_POINTS];
  int                  filled_prefix = 0;
  logic [CNT_REG_W-1:0] count_now = CNT_REG_W'(1);
  bit                  steady = 1'b0;
  longint              cycles = 0;

  lookahead_point_search #(.MAX_POINTS(MAX_POINTS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  lookahead_target_checker #(.MAX_POINTS(MAX_POINTS)) u_target_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lookahead_point_search failed");
      $finish;
    end
  end

  // idle length before the next item: mostly none or short, a few long
  function automatic int next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 320);
  endfunction

  function automatic int active_count(input logic [CNT_REG_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_POINTS) return MAX_POINTS;
    return int'(c);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord_full();
    return COORD_BITS'($urandom);
  endfunction

  // coordinate near a cluster center, now and then an extreme
  function automatic logic signed [COORD_BITS-1:0] rand_coord_near(input longint center,
                                                                    input longint spread);
    int unsigned r;
    longint      v;
    r = $urandom_range(0, 15);
    case (r)
      0: return clamp_coord(COORD_MIN);
      1: return clamp_coord(COORD_MAX);
      2: return '0;
      default: begin
        v = center + longint'($urandom_range(0, 32'(2 * spread))) - spread;
        return clamp_coord(v);
      end
    endcase
  endfunction

  // hold start low with junk on the item bus; nothing when n is zero
  task automatic pause_input(input int n);
    logic [63:0] junk;
    if (n > 0) begin
      junk = {$urandom, $urandom};
      @(negedge clk);
      start   <= 1'b0;
      in_item <= junk[$bits(in_item_t)-1:0];
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // offer one item and wait until the block takes it
  task automatic send_item(input in_item_t it);
    pause_input(next_gap());
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_point(input int slot, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
    in_item_t it;
    it.cmd        = CMD_LOAD;
    it.point_slot = SLOT_W'(slot);
    it.coord_x    = x;
    it.coord_y    = y;
    written[slot] = 1'b1;
    while (filled_prefix < MAX_POINTS && written[filled_prefix]) filled_prefix++;
    send_item(it);
  endtask

  task automatic query_at(input logic signed [COORD_BITS-1:0] x,
                          input logic signed [COORD_BITS-1:0] y);
    in_item_t it;
    it.cmd        = CMD_QUERY;
    it.point_slot = SLOT_W'($urandom);
    it.coord_x    = x;
    it.coord_y    = y;
    send_item(it);
  endtask

  // wait until every target has come and the block has gone quiet
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results != 0 || busy) @(posedge clk);
    repeat (MAX_POINTS + 8) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // register writes with junk in the unused upper bits
  task automatic set_radius(input logic [LA_W-1:0] radius);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[LA_W-1:0] = radius;
    reg_write(ADDR_LOOKAHEAD, word);
  endtask

  task automatic set_count(input logic [CNT_REG_W-1:0] c);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[CNT_REG_W-1:0] = c;
    reg_write(ADDR_COUNT, word);
    count_now = c;
  endtask

  initial begin
    logic signed [COORD_BITS-1:0] cmin;
    logic signed [COORD_BITS-1:0] cmax;
    logic [LA_W-1:0]              radius;
    logic [CNT_REG_W-1:0]         cnt;
    longint                       center_x;
    longint                       center_y;
    longint                       spread;
    int                           eff;
    int unsigned                  r;

    cmin    = clamp_coord(COORD_MIN);
    cmax    = clamp_coord(COORD_MAX);
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single point, zero radius: fallback to the only point
    load_point(0, '0, '0);
    query_at(cmin, cmax);
    wait_drained();
    // point count zero acts as one
    set_count('0);
    query_at(cmax, cmin);

    // full radius over extreme points
    wait_drained();
    set_radius(RADIUS_MAX);
    set_count(CNT_REG_W'(5));
    load_point(1, cmax, cmax);
    load_point(2, cmin, cmin);
    load_point(3, cmin, cmax);
    load_point(4, cmin, cmin);
    load_point(MAX_POINTS - 1, cmax, cmin);
    query_at('0, '0);
    // distance equal to the radius is not in range
    query_at(cmax, cmax);

    // zero radius: fallback to the point after the nearest, with ties
    wait_drained();
    set_radius('0);
    query_at(cmin, cmin);
    query_at(cmin, cmax);
    query_at(cmax, cmax);
    // nearest point is the last one in use
    wait_drained();
    set_count(CNT_REG_W'(4));
    query_at(cmin, cmax);

    // random phases over radius and point count settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin radius = LA_W'(1024); cnt = CNT_REG_W'(8); end
        1: begin radius = '0; cnt = CNT_REG_W'(16); end
        2: begin radius = RADIUS_MAX; cnt = CNT_REG_W'(3); end
        3: begin radius = LA_W'($urandom_range(1, 4096)); cnt = CNT_REG_W'(2); end
        4: begin radius = LA_W'($urandom); cnt = CNT_REG_W'(MAX_POINTS); end
        5: begin radius = LA_W'(300); cnt = '1; end
        6: begin radius = LA_W'($urandom); cnt = CNT_REG_W'(1); end
        default: begin radius = LA_W'($urandom); cnt = CNT_REG_W'($urandom_range(2, 64)); end
      endcase
      wait_drained();
      set_radius(radius);
      set_count(cnt);
      eff      = active_count(count_now);
      center_x = longint'(rand_coord_full());
      center_y = longint'(rand_coord_full());
      spread   = (radius == 0) ? 4096 : 2 * longint'(radius);
      if (spread > (longint'(1) << COORD_BITS)) spread = longint'(1) << COORD_BITS;

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        steady = (n % 100) < 25;
        if (filled_prefix < eff) begin
          // fill the points in use before any query scans them
          load_point(filled_prefix, rand_coord_near(center_x, spread),
                     rand_coord_near(center_y, spread));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 45)
            query_at(rand_coord_near(center_x, spread), rand_coord_near(center_y, spread));
          else if (r < 85)
            load_point($urandom_range(0, eff - 1), rand_coord_near(center_x, spread),
                       rand_coord_near(center_y, spread));
          else if (r < 95)
            load_point($urandom_range(0, MAX_POINTS - 1), rand_coord_full(),
                       rand_coord_full());
          else
            query_at(rand_coord_full(), rand_coord_full());
        end
      end
    end

    // drain and verdict
    steady = 1'b0;
    wait_drained();
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_lookahead_point_search passed");
    end else begin
      $display("tb_lookahead_point_search failed");
    end
    $finish;
  end

endmodule
